/* hw/rtl/phht_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phht_pkg
// Shared widths, fixed-point constants and types for the pitch hold
// hysteresis tracker.
// ----------------------------------------------------------------------------
package phht_pkg;

    localparam int FREQ_W  = 24;
    localparam int CONF_W  = 16;
    localparam int RATIO_W = 16;
    localparam int CNT_W   = 8;
    localparam int FRAC_W  = 16;
    localparam int K_W     = 17;
    localparam int PROD_W  = FREQ_W + K_W;
    localparam int NBANDS  = 3;

    // Ratio bounds in Q1.16
    localparam logic [K_W-1:0] JUMP_MAX = 17'd45022;
    localparam logic [K_W-1:0] CONFIRM_LO = 17'd59064;
    localparam logic [K_W-1:0] CONFIRM_HI = 17'd72717;
    localparam logic [NBANDS-1:0][K_W-1:0] BAND_LO = {17'd41001, 17'd30751, 17'd20500};
    localparam logic [NBANDS-1:0][K_W-1:0] BAND_HI = {17'd46557, 17'd34918, 17'd23278};

    localparam logic [RATIO_W-1:0] VETO_RATIO = 16'd640;
    localparam logic [CONF_W-1:0]  CONF_CAP   = 16'd36045;
    localparam logic [CNT_W-1:0]   CNT_MAX    = 8'hFF;
    localparam logic [CNT_W-1:0]   CONFIRM_RESET = 8'd2;

    // Frequency times each published-pitch bound
    typedef struct packed {
        logic [PROD_W-1:0]             jump;
        logic [NBANDS-1:0][PROD_W-1:0] band_lo;
        logic [NBANDS-1:0][PROD_W-1:0] band_hi;
    } pub_prod_t;

    // Frequency times the confirmation window bounds
    typedef struct packed {
        logic [PROD_W-1:0] lo;
        logic [PROD_W-1:0] hi;
    } pend_prod_t;

    typedef struct packed {
        logic              present;
        logic [FREQ_W-1:0] freq;
        logic [CONF_W-1:0] conf;
        logic              ratio_present;
        logic [RATIO_W-1:0] ratio;
        logic [PROD_W-1:0] lhs;
        pub_prod_t         pub;
        pend_prod_t        pend;
    } item_t;

endpackage

/* hw/rtl/phht_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phht_in_stage
// Input register. Forms the constant-bound products of the incoming
// frequency so the tracker only compares registered values.
// ----------------------------------------------------------------------------
module phht_in_stage
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             estimate_present,
    input  logic [phht_pkg::FREQ_W-1:0]      estimate_frequency,
    input  logic [phht_pkg::CONF_W-1:0]      estimate_confidence,
    input  logic                             upper_ratio_present,
    input  logic [phht_pkg::RATIO_W-1:0]     upper_ratio,
    output logic                             item_valid,
    input  logic                             item_ready,
    output phht_pkg::item_t                  item
);

    logic            valid_reg;
    logic            valid_next;
    phht_pkg::item_t item_reg;
    phht_pkg::item_t item_next;
    logic [phht_pkg::PROD_W-1:0] f_ext;

    assign in_ready   = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;
    assign f_ext      = phht_pkg::PROD_W'(estimate_frequency);

    always_comb
    begin
        item_next.present       = estimate_present;
        item_next.freq          = estimate_frequency;
        item_next.conf          = estimate_confidence;
        item_next.ratio_present = upper_ratio_present;
        item_next.ratio         = upper_ratio;
        item_next.lhs           = phht_pkg::PROD_W'({estimate_frequency,
                                                     {phht_pkg::FRAC_W{1'b0}}});
        item_next.pub.jump      = f_ext * phht_pkg::PROD_W'(phht_pkg::JUMP_MAX);
        for (int k = 0; k < phht_pkg::NBANDS; k++)
        begin
            item_next.pub.band_lo[k] = f_ext * phht_pkg::PROD_W'(phht_pkg::BAND_LO[k]);
            item_next.pub.band_hi[k] = f_ext * phht_pkg::PROD_W'(phht_pkg::BAND_HI[k]);
        end
        item_next.pend.lo = f_ext * phht_pkg::PROD_W'(phht_pkg::CONFIRM_LO);
        item_next.pend.hi = f_ext * phht_pkg::PROD_W'(phht_pkg::CONFIRM_HI);
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

/* hw/rtl/phht_track.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phht_track
// Tracker state, hold decision and result register. Compares the
// registered item against products kept for the published and pending
// pitch, updates state and loads one result per item.
// ----------------------------------------------------------------------------
module phht_track
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [phht_pkg::CNT_W-1:0]       cfg_data,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  phht_pkg::item_t                  item,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             pitch_valid,
    output logic [phht_pkg::FREQ_W-1:0]      pitch_frequency,
    output logic [phht_pkg::CONF_W-1:0]      pitch_confidence,
    output logic                             holding_old_pitch
);

    logic [phht_pkg::CNT_W-1:0]  need_cfg_reg;
    logic [phht_pkg::CNT_W-1:0]  need;

    logic                        pub_valid_reg, pub_valid_next;
    logic [phht_pkg::FREQ_W-1:0] pub_freq_reg, pub_freq_next;
    phht_pkg::pub_prod_t         pub_prod_reg, pub_prod_next;
    logic                        pend_valid_reg, pend_valid_next;
    phht_pkg::pend_prod_t        pend_prod_reg, pend_prod_next;
    logic [phht_pkg::CNT_W-1:0]  count_reg, count_next;

    logic                        out_valid_reg, out_valid_next;
    logic                        pv_next, hold_next;
    logic [phht_pkg::FREQ_W-1:0] pf_next;
    logic [phht_pkg::CONF_W-1:0] pc_next;
    logic                        pv_reg, hold_reg;
    logic [phht_pkg::FREQ_W-1:0] pf_reg;
    logic [phht_pkg::CONF_W-1:0] pc_reg;

    logic                        take;
    logic                        in_band;
    logic                        suspicious;
    logic                        confirm;
    logic [phht_pkg::CNT_W-1:0]  count_new;
    logic [phht_pkg::CONF_W-1:0] conf_capped;

    assign cfg_ready  = 1'b1;
    assign item_ready = !out_valid_reg || out_ready;
    assign take       = item_valid && item_ready;
    assign need       = (need_cfg_reg == '0) ? phht_pkg::CNT_W'(1) : need_cfg_reg;

    assign out_valid         = out_valid_reg;
    assign pitch_valid       = pv_reg;
    assign pitch_frequency   = pf_reg;
    assign pitch_confidence  = pc_reg;
    assign holding_old_pitch = hold_reg;

    always_comb
    begin
        in_band = 1'b0;
        for (int k = 0; k < phht_pkg::NBANDS; k++)
        begin
            if (item.lhs >= pub_prod_reg.band_lo[k] && item.lhs <= pub_prod_reg.band_hi[k])
            begin
                in_band = 1'b1;
            end
        end
        suspicious = (item.freq < pub_freq_reg) && (item.lhs <= pub_prod_reg.jump) && in_band;
        confirm    = pend_valid_reg && (item.lhs >= pend_prod_reg.lo)
                     && (item.lhs <= pend_prod_reg.hi);
        if (confirm)
        begin
            count_new = (count_reg != phht_pkg::CNT_MAX) ?
                        count_reg + phht_pkg::CNT_W'(1) : count_reg;
        end
        else
        begin
            count_new = phht_pkg::CNT_W'(1);
        end
        conf_capped = (item.conf < phht_pkg::CONF_CAP) ? item.conf : phht_pkg::CONF_CAP;
    end

    always_comb
    begin
        pub_valid_next  = pub_valid_reg;
        pub_freq_next   = pub_freq_reg;
        pub_prod_next   = pub_prod_reg;
        pend_valid_next = pend_valid_reg;
        pend_prod_next  = pend_prod_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        pv_next         = pv_reg;
        pf_next         = pf_reg;
        pc_next         = pc_reg;
        hold_next       = hold_reg;

        if (item_ready)
        begin
            out_valid_next = item_valid;
        end

        if (take)
        begin
            pv_next   = 1'b1;
            pf_next   = item.freq;
            pc_next   = item.conf;
            hold_next = 1'b0;
            if (!item.present)
            begin
                // silence
                pub_valid_next  = 1'b0;
                pub_freq_next   = '0;
                pub_prod_next   = '0;
                pend_valid_next = 1'b0;
                pend_prod_next  = '0;
                count_next      = '0;
                pv_next         = 1'b0;
                pf_next         = '0;
                pc_next         = '0;
            end
            else if (!pub_valid_reg || !suspicious)
            begin
                if (pub_valid_reg)
                begin
                    pend_valid_next = 1'b0;
                    pend_prod_next  = '0;
                    count_next      = '0;
                end
                pub_valid_next = 1'b1;
                pub_freq_next  = item.freq;
                pub_prod_next  = item.pub;
            end
            else if (item.ratio_present && item.ratio >= phht_pkg::VETO_RATIO)
            begin
                pend_valid_next = 1'b0;
                pend_prod_next  = '0;
                count_next      = '0;
                pf_next         = pub_freq_reg;
                pc_next         = conf_capped;
                hold_next       = 1'b1;
            end
            else if (!item.ratio_present)
            begin
                pend_valid_next = 1'b0;
                pend_prod_next  = '0;
                count_next      = '0;
                pub_freq_next   = item.freq;
                pub_prod_next   = item.pub;
            end
            else if (count_new >= need)
            begin
                pend_valid_next = 1'b0;
                pend_prod_next  = '0;
                count_next      = '0;
                pub_freq_next   = item.freq;
                pub_prod_next   = item.pub;
            end
            else
            begin
                count_next = count_new;
                if (!confirm)
                begin
                    pend_valid_next = 1'b1;
                    pend_prod_next  = item.pend;
                end
                pf_next   = pub_freq_reg;
                pc_next   = conf_capped;
                hold_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            need_cfg_reg   <= phht_pkg::CONFIRM_RESET;
            pub_valid_reg  <= 1'b0;
            pub_freq_reg   <= '0;
            pub_prod_reg   <= '0;
            pend_valid_reg <= 1'b0;
            pend_prod_reg  <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                need_cfg_reg <= cfg_data;
            end
            pub_valid_reg  <= pub_valid_next;
            pub_freq_reg   <= pub_freq_next;
            pub_prod_reg   <= pub_prod_next;
            pend_valid_reg <= pend_valid_next;
            pend_prod_reg  <= pend_prod_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pv_reg   <= pv_next;
        pf_reg   <= pf_next;
        pc_reg   <= pc_next;
        hold_reg <= hold_next;
    end

endmodule

/* hw/rtl/pitch_hold_hysteresis_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pitch_hold_hysteresis_tracker
// Per-frame pitch publisher that holds back suspected harmonic drops.
// ----------------------------------------------------------------------------
// One frame transfer is accepted every clock cycle while the result side does
// not stall, and each yields exactly one result transfer: the input register
// forms the frequency-times-bound products, and the tracker stage compares
// them against the products kept for the published and pending pitch,
// updates state and loads the result register. Stalls on the result side
// hold both stages; while the result waits the input register still takes
// one transfer if empty, so at most two frames are held in the block. The user
// writes required_confirmations via the cfg channel while idle; not enforced.
// ----------------------------------------------------------------------------
module pitch_hold_hysteresis_tracker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [phht_pkg::CNT_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             estimate_present,
    input  logic [phht_pkg::FREQ_W-1:0]      estimate_frequency,
    input  logic [phht_pkg::CONF_W-1:0]      estimate_confidence,
    input  logic                             upper_ratio_present,
    input  logic [phht_pkg::RATIO_W-1:0]     upper_ratio,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             pitch_valid,
    output logic [phht_pkg::FREQ_W-1:0]      pitch_frequency,
    output logic [phht_pkg::CONF_W-1:0]      pitch_confidence,
    output logic                             holding_old_pitch
);

    logic            item_valid;
    logic            item_ready;
    phht_pkg::item_t item;

    phht_in_stage u_in_stage
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .estimate_present    (estimate_present),
        .estimate_frequency  (estimate_frequency),
        .estimate_confidence (estimate_confidence),
        .upper_ratio_present (upper_ratio_present),
        .upper_ratio         (upper_ratio),
        .item_valid          (item_valid),
        .item_ready          (item_ready),
        .item                (item)
    );

    phht_track u_track
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .item_valid        (item_valid),
        .item_ready        (item_ready),
        .item              (item),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .pitch_valid       (pitch_valid),
        .pitch_frequency   (pitch_frequency),
        .pitch_confidence  (pitch_confidence),
        .holding_old_pitch (holding_old_pitch)
    );

    // hold republishes a pitch with capped confidence
    a_hold_capped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && holding_old_pitch |-> pitch_valid
            && pitch_confidence <= phht_pkg::CONF_CAP)
        else $error("hold result without valid pitch or with uncapped confidence");

    // silence result is all zero
    a_silence_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pitch_valid |-> pitch_frequency == '0
            && pitch_confidence == '0 && !holding_old_pitch)
        else $error("silence result not all zero");

    // input stage cannot run ahead while results stall
    a_stall_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && out_valid && !out_ready |-> !in_ready)
        else $error("input accepted while both stages are full");

endmodule
